// File: design/bcfk_pkg.sv
// Package for the bone chain forward kinematics unit.
// Holds fixed-point constants, the CORDIC arctangent table and shared types.
package bcfk_pkg;
    localparam int Q14_ONE = 16384;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] DEG90 = 34'sd5898240;
    localparam logic signed [33:0] DEG180 = 34'sd11796480;
    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    localparam logic [2:0] REG_ROOT_X = 3'd0;
    localparam logic [2:0] REG_ROOT_Y = 3'd1;
    localparam logic [2:0] REG_ROOT_Z = 3'd2;
    localparam logic [2:0] REG_LEN_0  = 3'd3;

    typedef logic signed [15:0] t_q14;
    typedef logic signed [23:0] t_pos;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0: atan_entry = 34'sd2949120;
            5'd1: atan_entry = 34'sd1740967;
            5'd2: atan_entry = 34'sd919879;
            5'd3: atan_entry = 34'sd466945;
            5'd4: atan_entry = 34'sd234379;
            5'd5: atan_entry = 34'sd117304;
            5'd6: atan_entry = 34'sd58666;
            5'd7: atan_entry = 34'sd29335;
            5'd8: atan_entry = 34'sd14668;
            5'd9: atan_entry = 34'sd7334;
            5'd10: atan_entry = 34'sd3667;
            5'd11: atan_entry = 34'sd1833;
            5'd12: atan_entry = 34'sd917;
            5'd13: atan_entry = 34'sd458;
            5'd14: atan_entry = 34'sd229;
            5'd15: atan_entry = 34'sd115;
            5'd16: atan_entry = 34'sd57;
            5'd17: atan_entry = 34'sd29;
            5'd18: atan_entry = 34'sd14;
            5'd19: atan_entry = 34'sd7;
            5'd20: atan_entry = 34'sd4;
            5'd21: atan_entry = 34'sd2;
            5'd22: atan_entry = 34'sd1;
            default: atan_entry = 34'sd0;
        endcase
    endfunction

    function automatic t_q14 clamp14(input logic signed [39:0] v);
        if (v > 40'sd16384) clamp14 = 16'sd16384;
        else if (v < -40'sd16384) clamp14 = -16'sd16384;
        else clamp14 = v[15:0];
    endfunction

    function automatic t_pos sat24(input logic signed [40:0] v);
        if (v > 41'sd8388607) sat24 = POS_MAX;
        else if (v < -41'sd8388608) sat24 = POS_MIN;
        else sat24 = v[23:0];
    endfunction
endpackage

// File: design/bcfk_if.sv
// Valid/ready channel interfaces for bone words and result words.
// Payload fields are plain logic vectors; no package is imported.
interface bcfk_bone_if;
    logic        valid;
    logic        ready;
    logic [1:0]  bone_index;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    modport source(output valid, bone_index, angle_x, angle_y, angle_z, input ready);
    modport sink(input valid, bone_index, angle_x, angle_y, angle_z, output ready);
endinterface

interface bcfk_result_if;
    logic valid;
    logic ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [23:0] pos_x, pos_y, pos_z;
    modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 pos_x, pos_y, pos_z, output ready);
endinterface

// File: design/bcfk_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on bcfk_pkg for the gain, the angle constants and the arctangent table.
module bcfk_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic signed [15:0] i_angle,
    output logic o_done,
    output bcfk_pkg::t_q14 o_sin,
    output bcfk_pkg::t_q14 o_cos
);
    import bcfk_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic signed [33:0] r_x, r_y, r_z;
    logic [CW-1:0] r_step;
    logic r_busy, r_neg, r_done;
    logic signed [33:0] z0, dx, dy, ang, xr, yr;

    always_comb begin
        z0 = {{9{i_angle[15]}}, i_angle, 9'd0};
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        ang = atan_entry(5'(r_step));
        xr = (r_x + 34'sd32768) >>> 16;
        yr = (r_y + 34'sd32768) >>> 16;
        if (r_neg) begin
            xr = -xr;
            yr = -yr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            if (z0 > DEG90) begin
                r_z <= z0 - DEG180;
                r_neg <= 1'b1;
            end else if (z0 < -DEG90) begin
                r_z <= z0 + DEG180;
                r_neg <= 1'b1;
            end else begin
                r_z <= z0;
                r_neg <= 1'b0;
            end
        end else if (r_busy) begin
            if (r_step == CW'(CORDIC_STEPS)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                o_cos <= clamp14(40'(xr));
                o_sin <= clamp14(40'(yr));
            end else begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_done = r_done;
endmodule

// File: design/bcfk_mac.sv
// Shared multiply-accumulate unit: one 16 by 17 product per cycle while i_en is high, into a wide sum.
// Depends on nothing beyond its ports.
module bcfk_mac (
    input  logic i_clk,
    input  logic i_clear,
    input  logic i_en,
    input  logic signed [15:0] i_a,
    input  logic signed [16:0] i_b,
    output logic signed [39:0] o_acc
);
    logic signed [39:0] r_acc;
    logic signed [32:0] prod;

    assign prod = i_a * i_b;

    // A clear together with an enable starts a new sum with the current product.
    always_ff @(posedge i_clk) begin
        if (i_clear) r_acc <= i_en ? 40'(prod) : '0;
        else if (i_en) r_acc <= r_acc + 40'(prod);
    end

    assign o_acc = r_acc;
endmodule

// File: design/bone_chain_forward_kinematics_unit.sv
// Bone chain forward kinematics unit: after a bone word is accepted the CORDIC runs once
// per axis (x, y, z) and the shared MAC forms the rotation Rx*Rz*Ry as two 3x3 products;
// for a bone after bone 0 it then advances the chain translation, forms world*R and the
// bone center, and an output state moves the result into the output register. A finished
// word waits in that register and only the next output state waits for it; a new bone word
// is taken only in idle. Synchronous active-low reset restores defaults.
module bone_chain_forward_kinematics_unit #(
    parameter int NUM_BONES = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    bcfk_bone_if.sink i_bone,
    bcfk_result_if.source o_res
);
    import bcfk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CORD, S_RXZ, S_RR, S_WR, S_LINK, S_CTR, S_OUT
    } t_state;

    t_state r_state;
    logic signed [15:0] r_root [3];
    logic [14:0] r_len [4];
    t_q14 r_world [9];
    t_pos r_wt [3];
    logic [14:0] r_prev;
    t_q14 r_ma [9];
    t_q14 r_mb [9];
    t_q14 r_out [9];
    t_pos r_pos [3];
    t_q14 r_res_m [9];
    t_pos r_res_p [3];
    logic [1:0] r_idx;
    logic signed [15:0] r_ang [3];
    t_q14 r_sin [3];
    t_q14 r_cos [3];
    logic [1:0] r_axis;
    logic r_cstart;
    logic [3:0] r_i, r_k;
    logic r_first;
    logic r_valid;

    logic c_done;
    t_q14 c_sin, c_cos;
    logic mac_clear, mac_en;
    logic signed [15:0] mac_a;
    logic signed [16:0] mac_b;
    logic signed [39:0] mac_acc;
    logic [14:0] cur_len;

    bcfk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cstart),
        .i_angle(r_ang[r_axis]), .o_done(c_done), .o_sin(c_sin), .o_cos(c_cos)
    );

    bcfk_mac u_mac (
        .i_clk(i_clk), .i_clear(mac_clear), .i_en(mac_en),
        .i_a(mac_a), .i_b(mac_b), .o_acc(mac_acc)
    );

    assign cur_len = r_len[r_idx];

    // r_i walks the output element, r_k the inner term; a clear happens at r_k == 0.
    logic [1:0] row, col, kk;
    logic [3:0] idx_a, idx_b, idx_c;
    logic signed [39:0] rnd14;
    logic signed [40:0] lnk, ctr;
    always_comb begin
        if (r_i >= 4'd6) begin
            row = 2'd2;
            col = 2'(r_i - 4'd6);
        end else if (r_i >= 4'd3) begin
            row = 2'd1;
            col = 2'(r_i - 4'd3);
        end else begin
            row = 2'd0;
            col = r_i[1:0];
        end
        kk = r_k[1:0];
        idx_a = {2'b00, row} * 4'd3 + {2'b00, kk};
        idx_b = {2'b00, kk} * 4'd3 + {2'b00, col};
        idx_c = {2'b00, r_i[1:0]} * 4'd3 + 4'd1;
        mac_clear = 1'b0;
        mac_en = 1'b0;
        mac_a = '0;
        mac_b = '0;
        case (r_state)
            S_RXZ, S_RR, S_WR: begin
                mac_en = (r_k < 4'd3);
                mac_clear = r_first;
                mac_a = r_ma[idx_a];
                mac_b = 17'(r_mb[idx_b]);
            end
            S_LINK: begin
                mac_en = r_k == 4'd0;
                mac_clear = r_first;
                mac_a = r_world[idx_c];
                mac_b = {2'b00, r_prev};
            end
            S_CTR: begin
                mac_en = r_k == 4'd0;
                mac_clear = r_first;
                mac_a = r_world[idx_c];
                mac_b = {2'b00, cur_len};
            end
            default: ;
        endcase
        rnd14 = (mac_acc + 40'sd8192) >>> 14;
        lnk = 41'(r_wt[r_i[1:0]]) + 41'(rnd14);
        ctr = 41'(r_wt[r_i[1:0]]) + 41'((mac_acc + 40'sd16384) >>> 15);
    end

    assign i_bone.ready = (r_state == S_IDLE);
    assign o_res.valid = r_valid;
    assign o_res.m00 = r_res_m[0];
    assign o_res.m01 = r_res_m[1];
    assign o_res.m02 = r_res_m[2];
    assign o_res.m10 = r_res_m[3];
    assign o_res.m11 = r_res_m[4];
    assign o_res.m12 = r_res_m[5];
    assign o_res.m20 = r_res_m[6];
    assign o_res.m21 = r_res_m[7];
    assign o_res.m22 = r_res_m[8];
    assign o_res.pos_x = r_res_p[0];
    assign o_res.pos_y = r_res_p[1];
    assign o_res.pos_z = r_res_p[2];

    always_ff @(posedge i_clk) begin
        r_cstart <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_root[0] <= 16'sd512;
            r_root[1] <= 16'sd256;
            r_root[2] <= 16'sd512;
            r_len[0] <= 15'd256;
            r_len[1] <= 15'd1024;
            r_len[2] <= 15'd768;
            r_len[3] <= 15'd512;
            for (int j = 0; j < 9; j++) r_world[j] <= (j % 4 == 0) ? 16'sd16384 : 16'sd0;
            for (int j = 0; j < 3; j++) r_wt[j] <= '0;
            r_prev <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index < REG_LEN_0) r_root[i_cfg_index[1:0]] <= i_cfg_data;
                else if (i_cfg_index <= 3'd6)
                    r_len[2'(i_cfg_index - REG_LEN_0)] <= i_cfg_data[14:0];
            end
            if (o_res.valid && o_res.ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_bone.valid && i_bone.ready &&
                            32'(i_bone.bone_index) < NUM_BONES) begin
                        r_idx <= i_bone.bone_index;
                        r_ang[0] <= i_bone.angle_x;
                        r_ang[1] <= i_bone.angle_y;
                        r_ang[2] <= i_bone.angle_z;
                        r_axis <= 2'd0;
                        r_cstart <= 1'b1;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (c_done) begin
                        r_sin[r_axis] <= c_sin;
                        r_cos[r_axis] <= c_cos;
                        if (r_axis == 2'd2) begin
                            // Rx into A, Rz into B.
                            r_ma[0] <= 16'sd16384; r_ma[1] <= '0; r_ma[2] <= '0;
                            r_ma[3] <= '0; r_ma[4] <= r_cos[0]; r_ma[5] <= -r_sin[0];
                            r_ma[6] <= '0; r_ma[7] <= r_sin[0]; r_ma[8] <= r_cos[0];
                            r_mb[0] <= c_cos; r_mb[1] <= -c_sin; r_mb[2] <= '0;
                            r_mb[3] <= c_sin; r_mb[4] <= c_cos; r_mb[5] <= '0;
                            r_mb[6] <= '0; r_mb[7] <= '0; r_mb[8] <= 16'sd16384;
                            r_i <= '0; r_k <= '0; r_first <= 1'b1;
                            r_state <= S_RXZ;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                            r_cstart <= 1'b1;
                        end
                    end
                end
                S_RXZ, S_RR, S_WR: begin
                    r_first <= 1'b0;
                    if (r_k == 4'd3) begin
                        r_out[r_i] <= clamp14(rnd14);
                        r_k <= '0;
                        r_first <= 1'b1;
                        if (r_i == 4'd8) begin
                            r_i <= '0;
                            if (r_state == S_RXZ) begin
                                for (int j = 0; j < 8; j++) r_ma[j] <= r_out[j];
                                r_ma[8] <= clamp14(rnd14);
                                r_mb[0] <= r_cos[1]; r_mb[1] <= '0; r_mb[2] <= r_sin[1];
                                r_mb[3] <= '0; r_mb[4] <= 16'sd16384; r_mb[5] <= '0;
                                r_mb[6] <= -r_sin[1]; r_mb[7] <= '0; r_mb[8] <= r_cos[1];
                                r_state <= S_RR;
                            end else if (r_state == S_RR) begin
                                if (r_idx == 2'd0) begin
                                    for (int j = 0; j < 8; j++) r_world[j] <= r_out[j];
                                    r_world[8] <= clamp14(rnd14);
                                    r_wt[0] <= 24'(r_root[0]);
                                    r_wt[1] <= 24'(r_root[1]) - 24'(r_len[0] >> 1);
                                    r_wt[2] <= 24'(r_root[2]);
                                    for (int j = 0; j < 9; j++)
                                        r_out[j] <= (j % 4 == 0) ? 16'sd16384 : 16'sd0;
                                    for (int j = 0; j < 3; j++) r_pos[j] <= 24'(r_root[j]);
                                    r_prev <= r_len[0];
                                    r_state <= S_OUT;
                                end else begin
                                    for (int j = 0; j < 8; j++) r_mb[j] <= r_out[j];
                                    r_mb[8] <= clamp14(rnd14);
                                    for (int j = 0; j < 9; j++) r_ma[j] <= r_world[j];
                                    r_state <= S_LINK;
                                end
                            end else begin
                                for (int j = 0; j < 8; j++) r_world[j] <= r_out[j];
                                r_world[8] <= clamp14(rnd14);
                                r_state <= S_CTR;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_LINK, S_CTR: begin
                    r_first <= 1'b0;
                    if (r_k == 4'd1) begin
                        if (r_state == S_LINK) r_wt[r_i[1:0]] <= sat24(lnk);
                        else r_pos[r_i[1:0]] <= sat24(ctr);
                        r_k <= '0;
                        r_first <= 1'b1;
                        if (r_i == 4'd2) begin
                            r_i <= '0;
                            if (r_state == S_LINK) begin
                                r_state <= S_WR;
                            end else begin
                                for (int j = 0; j < 9; j++) r_out[j] <= r_world[j];
                                r_prev <= cur_len;
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: begin
                    // The output register takes the word once the previous one is gone.
                    if (!r_valid || o_res.ready) begin
                        for (int j = 0; j < 9; j++) r_res_m[j] <= r_out[j];
                        for (int j = 0; j < 3; j++) r_res_p[j] <= r_pos[j];
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/tb.sv
// Testbench for the bone chain forward kinematics unit: directed table plus random bone words.
// Depends on bcfk_pkg and the bcfk_bone_if / bcfk_result_if channel interfaces.
`timescale 1ns / 100ps

module tb;
    import bcfk_pkg::*;

    localparam int NUM_BONES = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY = 160;
    localparam int CYCLE_LIMIT = 1200000;
    localparam int RANDOM_PER_PHASE = 560;
    localparam logic [2:0] REG_BAD = 3'd7;

    typedef longint t_mat[9];
    typedef struct {
        t_q14 m[9];
        t_pos p[3];
    } t_pose;
    typedef struct {
        logic [1:0] bone;
        int ax, ay, az;
        bit known;
        int px, py, pz;
    } t_row;

    localparam int NROWS = 19;
    // Rows marked known expect an identity rotation and the given center.
    t_row dir_rows[NROWS] = '{
        '{2'd2, 0, 0, 0, 1'b0, 0, 0, 0},
        '{2'd0, 0, 0, 0, 1'b1, 512, 256, 512},
        '{2'd1, 0, 0, 0, 1'b1, 512, 896, 512},
        '{2'd0, 11520, -11520, 11520, 1'b1, 512, 256, 512},
        '{2'd1, 11520, 0, 0, 1'b0, 0, 0, 0},
        '{2'd2, 0, 11520, 0, 1'b0, 0, 0, 0},
        '{2'd3, 0, 0, 11520, 1'b0, 0, 0, 0},
        '{2'd0, 0, 0, 0, 1'b1, 512, 256, 512},
        '{2'd1, -11520, -11520, -11520, 1'b0, 0, 0, 0},
        '{2'd2, 23040, -23040, 23040, 1'b0, 0, 0, 0},
        '{2'd3, -23040, 23040, -23040, 1'b0, 0, 0, 0},
        '{2'd0, 32767, -32768, 32767, 1'b1, 512, 256, 512},
        '{2'd1, 32767, 32767, 32767, 1'b0, 0, 0, 0},
        '{2'd2, -32768, -32768, -32768, 1'b0, 0, 0, 0},
        '{2'd3, 11521, -11521, 11519, 1'b0, 0, 0, 0},
        '{2'd1, 5760, 1000, -3000, 1'b0, 0, 0, 0},
        '{2'd3, -11519, 17280, -17280, 1'b0, 0, 0, 0},
        '{2'd2, 1, -1, 1, 1'b0, 0, 0, 0},
        '{2'd0, -23040, 23040, -11521, 1'b1, 512, 256, 512}
    };

    localparam longint ATAN[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    bcfk_bone_if bone_ch ();
    bcfk_result_if res_ch ();

    bone_chain_forward_kinematics_unit #(
        .NUM_BONES(NUM_BONES), .CORDIC_STEPS(CORDIC_STEPS)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_bone(bone_ch.sink), .o_res(res_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // Chain state and register copy of the predictor.
    t_mat world_rot;
    longint world_pos[3];
    longint prev_len;
    longint root_cfg[3];
    longint len_cfg[4];

    t_pose pending_poses[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int cycles = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void cordic_sin_cos(longint ang, output longint s, output longint c);
        longint z, x, y, nx, dx, dy;
        bit flip;
        z = ang * 512;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 5898240) begin
            z -= 11796480;
            flip = 1;
        end else if (z < -5898240) begin
            z += 11796480;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                nx = x - dx; y = y + dy; z -= ATAN[i];
            end else begin
                nx = x + dx; y = y - dy; z += ATAN[i];
            end
            x = nx;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip(x, -Q14_ONE, Q14_ONE);
        s = clip(y, -Q14_ONE, Q14_ONE);
    endfunction

    function automatic t_mat mat_product(t_mat a, t_mat b);
        t_mat r;
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
                r[i*3+j] = clip((acc + 8192) >>> 14, -Q14_ONE, Q14_ONE);
            end
        return r;
    endfunction

    // Advances the chain by one bone and returns the pose the block must emit.
    function automatic t_pose chain_advance(logic [1:0] bone, int ax, int ay, int az);
        longint sx, cx, sy, cy, sz, cz, len, d;
        t_mat rx, ry, rz, r;
        t_pose pose;
        cordic_sin_cos(ax, sx, cx);
        cordic_sin_cos(ay, sy, cy);
        cordic_sin_cos(az, sz, cz);
        rx = '{Q14_ONE, 0, 0, 0, cx, -sx, 0, sx, cx};
        ry = '{cy, 0, sy, 0, Q14_ONE, 0, -sy, 0, cy};
        rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, Q14_ONE};
        r = mat_product(mat_product(rx, rz), ry);
        len = len_cfg[bone];
        if (bone == 0) begin
            world_rot = r;
            world_pos[0] = root_cfg[0];
            world_pos[1] = root_cfg[1] - (len >>> 1);
            world_pos[2] = root_cfg[2];
            for (int i = 0; i < 9; i++) pose.m[i] = t_q14'((i % 4 == 0) ? Q14_ONE : 0);
            for (int i = 0; i < 3; i++) pose.p[i] = t_pos'(root_cfg[i]);
        end else begin
            for (int i = 0; i < 3; i++) begin
                d = (world_rot[i*3+1] * prev_len + 8192) >>> 14;
                world_pos[i] = clip(world_pos[i] + d, -8388608, 8388607);
            end
            world_rot = mat_product(world_rot, r);
            for (int i = 0; i < 9; i++) pose.m[i] = t_q14'(world_rot[i]);
            for (int i = 0; i < 3; i++) begin
                d = (world_rot[i*3+1] * len + 16384) >>> 15;
                pose.p[i] = t_pos'(clip(world_pos[i] + d, -8388608, 8388607));
            end
        end
        prev_len = len;
        return pose;
    endfunction

    task automatic write_reg(logic [2:0] index, logic [15:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index <= REG_ROOT_Z) root_cfg[index[1:0]] = longint'(signed'(data));
        else if (index < REG_BAD) len_cfg[2'(index - REG_LEN_0)] = data[14:0];
    endtask

    // Sends one bone word; returns after the edge that accepted it.
    task automatic send_bone(logic [1:0] bone, int ax, int ay, int az, output t_pose pose);
        while ($urandom_range(99) < send_idle_pct) begin
            bone_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        bone_ch.valid = 1'b1;
        bone_ch.bone_index = bone;
        bone_ch.angle_x = 16'(ax);
        bone_ch.angle_y = 16'(ay);
        bone_ch.angle_z = 16'(az);
        do @(posedge i_clk); while (!bone_ch.ready);
        // A bone index beyond the chain is taken but leaves the chain untouched.
        if (32'(bone) < NUM_BONES) pose = chain_advance(bone, ax, ay, az);
        words_in++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        bone_ch.valid = 1'b0;
        while (pending_poses.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    function automatic int random_angle();
        case ($urandom_range(9))
            0: return $urandom_range(65535) - 32768;
            1: return ($urandom_range(1)) ? 23040 : -23040;
            2: return ($urandom_range(1)) ? 11520 : -11520;
            default: return int'($urandom_range(46080)) - 23040;
        endcase
    endfunction

    task automatic random_bones(int count);
        t_pose pose;
        logic [1:0] bone;
        bone = 0;
        for (int n = 0; n < count; n++) begin
            // Mostly whole chains from the base; now and then a random jump.
            if ($urandom_range(99) < 12) bone = 2'($urandom_range(3));
            send_bone(bone, random_angle(), random_angle(), random_angle(), pose);
            if (32'(bone) < NUM_BONES) pending_poses = {pending_poses, pose};
            bone = bone + 2'd1;
        end
    endtask

    // Result side: random stalls, a long hold-off on request, and the checker.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            res_ch.ready <= 1'b0;
            hold_request <= hold_request - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            words_out++;
            if (pending_poses.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = pending_poses.pop_front();
                if (res_ch.m00 !== want.m[0]) begin $error("m00 exp %0d got %0d", want.m[0], res_ch.m00); errors++; end
                if (res_ch.m01 !== want.m[1]) begin $error("m01 exp %0d got %0d", want.m[1], res_ch.m01); errors++; end
                if (res_ch.m02 !== want.m[2]) begin $error("m02 exp %0d got %0d", want.m[2], res_ch.m02); errors++; end
                if (res_ch.m10 !== want.m[3]) begin $error("m10 exp %0d got %0d", want.m[3], res_ch.m10); errors++; end
                if (res_ch.m11 !== want.m[4]) begin $error("m11 exp %0d got %0d", want.m[4], res_ch.m11); errors++; end
                if (res_ch.m12 !== want.m[5]) begin $error("m12 exp %0d got %0d", want.m[5], res_ch.m12); errors++; end
                if (res_ch.m20 !== want.m[6]) begin $error("m20 exp %0d got %0d", want.m[6], res_ch.m20); errors++; end
                if (res_ch.m21 !== want.m[7]) begin $error("m21 exp %0d got %0d", want.m[7], res_ch.m21); errors++; end
                if (res_ch.m22 !== want.m[8]) begin $error("m22 exp %0d got %0d", want.m[8], res_ch.m22); errors++; end
                if (res_ch.pos_x !== want.p[0]) begin $error("pos_x exp %0d got %0d", want.p[0], res_ch.pos_x); errors++; end
                if (res_ch.pos_y !== want.p[1]) begin $error("pos_y exp %0d got %0d", want.p[1], res_ch.pos_y); errors++; end
                if (res_ch.pos_z !== want.p[2]) begin $error("pos_z exp %0d got %0d", want.p[2], res_ch.pos_z); errors++; end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles,
                     pending_poses.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_pose pose;
        bone_ch.valid = 1'b0;
        bone_ch.bone_index = '0;
        bone_ch.angle_x = '0;
        bone_ch.angle_y = '0;
        bone_ch.angle_z = '0;
        res_ch.ready = 1'b0;
        world_rot = '{Q14_ONE, 0, 0, 0, Q14_ONE, 0, 0, 0, Q14_ONE};
        world_pos = '{0, 0, 0};
        prev_len = 0;
        root_cfg = '{512, 256, 512};
        len_cfg = '{256, 1024, 768, 512};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part runs on the reset register values.
        for (int r = 0; r < NROWS; r++) begin
            send_bone(dir_rows[r].bone, dir_rows[r].ax, dir_rows[r].ay, dir_rows[r].az, pose);
            if (dir_rows[r].known) begin
                for (int i = 0; i < 9; i++) pose.m[i] = t_q14'((i % 4 == 0) ? Q14_ONE : 0);
                pose.p[0] = t_pos'(dir_rows[r].px);
                pose.p[1] = t_pos'(dir_rows[r].py);
                pose.p[2] = t_pos'(dir_rows[r].pz);
            end
            if (32'(dir_rows[r].bone) < NUM_BONES) pending_poses = {pending_poses, pose};
        end
        drain();

        // Extreme registers; an out-of-range index must be ignored.
        write_reg(REG_ROOT_X, 16'h7FFF);
        write_reg(REG_ROOT_Y, 16'h8000);
        write_reg(REG_ROOT_Z, 16'h0000);
        write_reg(REG_LEN_0, 16'h7FFF);
        write_reg(REG_LEN_0 + 3'd1, 16'h0000);
        write_reg(REG_LEN_0 + 3'd2, 16'hFFFF);
        write_reg(REG_LEN_0 + 3'd3, 16'h0001);
        write_reg(REG_BAD, 16'h1234);
        send_idle_pct = 30;
        recv_idle_pct = 65;
        random_bones(RANDOM_PER_PHASE);
        drain();

        write_reg(REG_ROOT_X, 16'h8000);
        write_reg(REG_ROOT_Y, 16'h7FFF);
        write_reg(REG_ROOT_Z, 16'h8000);
        write_reg(REG_LEN_0, 16'h0000);
        write_reg(REG_LEN_0 + 3'd1, 16'h7FFF);
        write_reg(REG_LEN_0 + 3'd2, 16'h7FFF);
        write_reg(REG_LEN_0 + 3'd3, 16'h7FFF);
        send_idle_pct = 65;
        recv_idle_pct = 30;
        random_bones(RANDOM_PER_PHASE);
        drain();

        for (int i = 0; i < 7; i++) write_reg(i[2:0], 16'($urandom_range(65535)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // The result side stalls for a long stretch while bones keep coming.
        hold_request = 600;
        random_bones(RANDOM_PER_PHASE);
        drain();

        $display("%0d bone words sent, %0d result words checked over four register settings",
                 words_in, words_out);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
